>>> rtl/gain_ramped_stream_mixer_unit_macros.svh
// assertion macros for the gain ramped stream mixer
// expects signals clk and rst in the scope that uses them
`ifndef GAIN_RAMPED_STREAM_MIXER_UNIT_MACROS_SVH
`define GAIN_RAMPED_STREAM_MIXER_UNIT_MACROS_SVH

// same-cycle implication
`define GMX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gmx check failed");

// next-cycle implication
`define GMX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gmx check failed");

`endif

>>> rtl/gmx_pkg.sv
// shared constants for the gain ramped stream mixer
// no dependencies
`default_nettype none
package gmx_pkg;
  localparam int STREAMS          = 32;
  localparam int MAX_BLOCK_FRAMES = 4096;
  localparam int SLOT_W   = 5;
  localparam int GAIN_W   = 18;
  localparam int FRAMES_W = 13;
  localparam int SMP_W    = 24;
  localparam int STEP_W   = 33;
  // running gain keeps growing when one slot is sampled several times in a frame
  localparam int RUN_W    = 41;
  localparam int SUM_W    = 32;

  localparam logic [2:0] OP_SET_GAIN = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_BEGIN    = 3'd3;
  localparam logic [2:0] OP_SAMPLE   = 3'd4;

  localparam logic RES_FRAME = 1'b0;
  localparam logic RES_GRANT = 1'b1;
endpackage
`default_nettype wire

>>> rtl/gmx_div.sv
// restoring divider for gain ramp steps, one quotient bit per cycle
// depends on gmx_pkg
`default_nettype none
module gmx_div import gmx_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [STEP_W-1:0] numer,
  input  wire logic [FRAMES_W-1:0]      denom,
  output logic                          done,
  output logic signed [STEP_W-1:0]      quotient
);
  localparam int MAG_W = STEP_W - 1;

  logic               busy;
  logic [5:0]         count;
  logic               neg;
  logic [MAG_W-1:0]   quo;
  logic [FRAMES_W-1:0] rem;
  logic [FRAMES_W-1:0] dvs;
  logic [FRAMES_W:0]  rem_sh;
  logic               fits;
  logic [STEP_W-1:0]  mag_full;

  assign mag_full = numer[STEP_W-1] ? STEP_W'(-numer) : STEP_W'(numer);
  assign rem_sh   = {rem, quo[MAG_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'(MAG_W);
        neg   <= numer[STEP_W-1];
        quo   <= mag_full[MAG_W-1:0];
        rem   <= '0;
        dvs   <= denom;
      end else if (busy) begin
        rem   <= fits ? FRAMES_W'(rem_sh - {1'b0, dvs}) : rem_sh[FRAMES_W-1:0];
        quo   <= {quo[MAG_W-2:0], fits};
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
endmodule
`default_nettype wire

>>> rtl/gain_ramped_stream_mixer_unit.sv
// top level of the gain ramped stream mixer: control, gain memories, mix datapath
// depends on gmx_pkg, gmx_div and gain_ramped_stream_mixer_unit_macros.svh
//
// Items are taken one at a time. A set gain item writes the gain memory. A sample
// item is dropped when no block is open, goes straight to close for a slot that
// is not playing and runs read, gain update, multiply, accumulate and close for a
// playing slot; closing a frame adds the output step. Start and the end of a block
// sweep all 32 slots, with a fetch step for each selected slot (set mask bit at
// start, playing bit at the end). Begin block sweeps the slots too, and each
// playing slot waits on the serial step divider. A result waits in an output
// register and holds further input only if a second result is due first.
`default_nettype none
`include "gain_ramped_stream_mixer_unit_macros.svh"
module gain_ramped_stream_mixer_unit import gmx_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // apb configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // stream_slot[4:0] target_gain[22:5] stream_mask[54:23] block_frames[67:55]
  // sample_left[91:68] sample_right[115:92], zero fill to 119
  input  wire logic [119:0] s_tdata,
  // opcode[2:0]
  input  wire logic [2:0]   s_tuser,
  // frame_last
  input  wire logic         s_tlast,
  // output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // mix_left[23:0] mix_right[47:24] frames_granted[60:48] mixer_active[61], zero fill
  output logic [63:0]       m_tdata,
  // result_kind[0]
  output logic [0:0]        m_tuser
);
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_GAIN_WR = 10'b0000000010,
    ST_SCAN    = 10'b0000000100,
    ST_FETCH   = 10'b0000001000,
    ST_DIV     = 10'b0000010000,
    ST_SMP_UPD = 10'b0000100000,
    ST_SMP_MUL = 10'b0001000000,
    ST_SMP_ACC = 10'b0010000000,
    ST_SMP_END = 10'b0100000000,
    ST_OUT     = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    MODE_START  = 2'd0,
    MODE_BEGIN  = 2'd1,
    MODE_COMMIT = 2'd2
  } mode_t;

  localparam int A_W = 2 * GAIN_W;
  localparam int B_W = STEP_W + RUN_W;
  localparam int PROD_W = SMP_W + RUN_W;
  localparam int SH_W = PROD_W - 30;

  // input field views
  logic [SLOT_W-1:0]   in_slot;
  logic [GAIN_W-1:0]   in_gain;
  logic [31:0]         in_mask;
  logic [FRAMES_W-1:0] in_frames;
  assign in_slot   = s_tdata[4:0];
  assign in_gain   = s_tdata[22:5];
  assign in_mask   = s_tdata[54:23];
  assign in_frames = s_tdata[67:55];

  state_t              state;
  mode_t               mode;
  logic [5:0]          streams_in_use;
  logic [5:0]          lim;
  logic [5:0]          idx;
  logic [SLOT_W-1:0]   slot_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [31:0]         mask_q;
  logic [FRAMES_W-1:0] frames_q;
  logic signed [SMP_W-1:0] sl_q, sr_q;
  logic                last_q;
  logic [31:0]         playing;
  logic                active_flag;
  logic [FRAMES_W-1:0] frames_left;
  logic signed [SUM_W-1:0] sum_l, sum_r;
  logic                any_mixed;
  logic                res_kind;
  logic signed [SMP_W-1:0] res_l, res_r;
  logic [FRAMES_W-1:0] res_grant;

  // gain memory: target and previous
  logic [A_W-1:0]      gain_mem [STREAMS];
  logic [STREAMS-1:0]  gain_valid;
  logic [SLOT_W-1:0]   a_raddr, a_waddr;
  logic                a_we;
  logic [A_W-1:0]      a_wdata, a_rdata;
  logic                a_rvalid;
  logic [GAIN_W-1:0]   rd_tgt, rd_prev;

  // ramp memory: step and running gain
  logic [B_W-1:0]      ramp_mem [STREAMS];
  logic [SLOT_W-1:0]   b_raddr, b_waddr;
  logic                b_we;
  logic [B_W-1:0]      b_wdata, b_rdata;

  logic                div_start, div_done;
  logic signed [STEP_W-1:0] div_numer, div_quo;
  logic signed [GAIN_W:0]   gain_diff;
  logic [RUN_W-1:0]    run_init_q;
  logic signed [RUN_W-1:0] run_new, run_q;
  logic signed [PROD_W-1:0] prod_l, prod_r;
  logic                out_free;
  logic                sel_bit;
  logic [FRAMES_W-1:0] fr_clip;
  logic [FRAMES_W-1:0] frames_dec;

  assign lim      = (streams_in_use > 6'(STREAMS)) ? 6'(STREAMS) : streams_in_use;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {26'd0, streams_in_use};

  assign rd_tgt  = a_rvalid ? a_rdata[A_W-1:GAIN_W] : '0;
  assign rd_prev = a_rvalid ? a_rdata[GAIN_W-1:0] : '0;

  assign a_raddr = (state == ST_IDLE) ? in_slot : idx[SLOT_W-1:0];
  assign b_raddr = (state == ST_IDLE) ? in_slot : slot_q;

  // sweep slot selection
  always_comb begin
    case (mode)
      MODE_START, MODE_BEGIN: sel_bit = (idx < lim) && mask_q[idx[SLOT_W-1:0]];
      MODE_COMMIT:            sel_bit = playing[idx[SLOT_W-1:0]];
      default:                sel_bit = 1'b0;
    endcase
  end

  // memory write ports
  always_comb begin
    a_we    = 1'b0;
    a_waddr = idx[SLOT_W-1:0];
    a_wdata = {rd_tgt, rd_tgt};
    b_we    = 1'b0;
    b_waddr = idx[SLOT_W-1:0];
    b_wdata = {div_quo, run_init_q};
    if (state == ST_GAIN_WR) begin
      a_we    = 1'b1;
      a_waddr = slot_q;
      a_wdata = {gain_q, rd_prev};
    end else if (state == ST_FETCH && mode != MODE_BEGIN) begin
      a_we = 1'b1;
    end
    if (state == ST_DIV && div_done) begin
      b_we = 1'b1;
    end else if (state == ST_SMP_UPD) begin
      b_we    = 1'b1;
      b_waddr = slot_q;
      b_wdata = {b_rdata[B_W-1:RUN_W], run_new};
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) gain_mem[a_waddr] <= a_wdata;
    a_rdata  <= gain_mem[a_raddr];
    a_rvalid <= gain_valid[a_raddr];
    if (b_we) ramp_mem[b_waddr] <= b_wdata;
    b_rdata <= ramp_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) gain_valid <= '0;
    else if (a_we) gain_valid[a_waddr] <= 1'b1;
  end

  // step division
  assign gain_diff = $signed({1'b0, rd_tgt}) - $signed({1'b0, rd_prev});
  assign div_numer = STEP_W'(gain_diff) <<< 14;
  assign div_start = (state == ST_FETCH) && (mode == MODE_BEGIN);

  gmx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_numer),
    .denom    (frames_q),
    .done     (div_done),
    .quotient (div_quo)
  );

  // mix datapath
  assign run_new = $signed(b_rdata[RUN_W-1:0]) + RUN_W'($signed(b_rdata[B_W-1:RUN_W]));
  assign fr_clip = (in_frames > FRAMES_W'(MAX_BLOCK_FRAMES)) ? FRAMES_W'(MAX_BLOCK_FRAMES)
                                                             : in_frames;
  assign frames_dec = frames_left - FRAMES_W'(1);

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SH_W-1:0] b);
    logic signed [SH_W+1:0] s;
    s = (SH_W+2)'(a) + (SH_W+2)'(b);
    if (s > (SH_W+2)'(64'sd2147483647)) return {1'b0, {(SUM_W-1){1'b1}}};
    if (s < (SH_W+2)'(-64'sd2147483648)) return {1'b1, {(SUM_W-1){1'b0}}};
    return s[SUM_W-1:0];
  endfunction

  function automatic logic signed [SMP_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32'sd8388607)) return 24'sh7fffff;
    if (v < -SUM_W'(32'sd8388608)) return 24'sh800000;
    return v[SMP_W-1:0];
  endfunction

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) streams_in_use <= '0;
    else if (psel && penable && pwrite && pready && !paddr[2]) streams_in_use <= pwdata[5:0];
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode        <= MODE_START;
      idx         <= '0;
      playing     <= '0;
      active_flag <= 1'b0;
      frames_left <= '0;
      sum_l       <= '0;
      sum_r       <= '0;
      any_mixed   <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            slot_q <= in_slot;
            gain_q <= in_gain;
            mask_q <= in_mask;
            sl_q   <= s_tdata[91:68];
            sr_q   <= s_tdata[115:92];
            last_q <= s_tlast;
            idx    <= '0;
            case (s_tuser)
              OP_SET_GAIN: state <= ST_GAIN_WR;
              OP_START, OP_STOP: begin
                if (s_tuser == OP_STOP || active_flag) begin
                  active_flag <= 1'b0;
                  frames_left <= '0;
                  sum_l <= '0;
                  sum_r <= '0;
                  any_mixed <= 1'b0;
                  playing <= '0;
                end
                mode  <= MODE_START;
                state <= (s_tuser == OP_START) ? ST_SCAN : ST_IDLE;
              end
              OP_BEGIN: begin
                res_kind  <= RES_GRANT;
                res_l     <= '0;
                res_r     <= '0;
                res_grant <= '0;
                if (active_flag && fr_clip != '0) begin
                  frames_q    <= fr_clip;
                  res_grant   <= fr_clip;
                  frames_left <= fr_clip;
                  sum_l <= '0;
                  sum_r <= '0;
                  any_mixed <= 1'b0;
                  playing <= '0;
                  mode  <= MODE_BEGIN;
                  state <= ST_SCAN;
                end else begin
                  state <= ST_OUT;
                end
              end
              OP_SAMPLE: begin
                if (frames_left == '0) state <= ST_IDLE;
                else if (({1'b0, in_slot} < lim) && playing[in_slot]) state <= ST_SMP_UPD;
                else state <= ST_SMP_END;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_GAIN_WR: state <= ST_IDLE;
        ST_SCAN: begin
          if (idx == 6'(STREAMS)) begin
            case (mode)
              MODE_START: state <= ST_IDLE;
              MODE_BEGIN: state <= ST_OUT;
              default: begin
                if (!any_mixed) active_flag <= 1'b0;
                frames_left <= '0;
                sum_l <= '0;
                sum_r <= '0;
                any_mixed <= 1'b0;
                playing <= '0;
                state <= ST_OUT;
              end
            endcase
          end else if (sel_bit) begin
            state <= ST_FETCH;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        ST_FETCH: begin
          if (mode == MODE_BEGIN) begin
            run_init_q <= RUN_W'({rd_prev, 14'd0});
            state <= ST_DIV;
          end else begin
            if (mode == MODE_START) active_flag <= 1'b1;
            idx   <= idx + 6'd1;
            state <= ST_SCAN;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            playing[idx[SLOT_W-1:0]] <= 1'b1;
            idx   <= idx + 6'd1;
            state <= ST_SCAN;
          end
        end
        ST_SMP_UPD: begin
          run_q <= run_new;
          state <= ST_SMP_MUL;
        end
        ST_SMP_MUL: begin
          prod_l <= PROD_W'(sl_q) * PROD_W'(run_q);
          prod_r <= PROD_W'(sr_q) * PROD_W'(run_q);
          state  <= ST_SMP_ACC;
        end
        ST_SMP_ACC: begin
          sum_l <= sat_add(sum_l, prod_l[PROD_W-1:30]);
          sum_r <= sat_add(sum_r, prod_r[PROD_W-1:30]);
          any_mixed <= 1'b1;
          state <= ST_SMP_END;
        end
        ST_SMP_END: begin
          if (!last_q) begin
            state <= ST_IDLE;
          end else begin
            res_kind  <= RES_FRAME;
            res_l     <= sat24(sum_l);
            res_r     <= sat24(sum_r);
            res_grant <= '0;
            sum_l <= '0;
            sum_r <= '0;
            frames_left <= frames_dec;
            idx <= '0;
            if (frames_dec == '0) begin
              mode  <= MODE_COMMIT;
              state <= ST_SCAN;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_kind;
            m_tdata  <= {2'b00, active_flag, res_grant, res_r, res_l};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `GMX_ASSERT_NOW(a_block_needs_active, frames_left != '0, active_flag)
  `GMX_ASSERT_NOW(a_div_done_in_div, div_done, state == ST_DIV)
  `GMX_ASSERT_NEXT(a_out_load, state == ST_OUT && out_free, m_tvalid && state == ST_IDLE)
endmodule
`default_nettype wire
